### hw/rtl/dstwr_pkg.sv
// Shared types, codes and sizes for the two-way ranging responder.
package dstwr_pkg;

    localparam int TS_WIDTH    = 40;
    localparam int SPAN_WIDTH  = 32;
    localparam int ID_WIDTH    = 8;
    localparam int TICK_WIDTH  = 8;
    localparam int RETRY_WIDTH = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 2;

    // Command queue between the classifier and the command sequencer.
    // The depth must stay a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input event codes.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_RX_ERR  = 2'd2;
    localparam logic [1:0] OP_TX_DONE = 2'd3;

    // Radio command codes.
    localparam logic [2:0] ACT_RESPONSE = 3'd0;
    localparam logic [2:0] ACT_ERROR    = 3'd1;
    localparam logic [2:0] ACT_TIMING   = 3'd2;
    localparam logic [2:0] ACT_RESTART  = 3'd3;
    localparam logic [2:0] ACT_RESET    = 3'd4;

    // Ranging stage numbers carried in frames.
    localparam logic [3:0] FRAME_POLL  = 4'd1;
    localparam logic [3:0] FRAME_FINAL = 4'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd2;

    // Configuration reset values.
    localparam logic [ID_WIDTH-1:0]    ANCHOR_ID_RST   = 8'd1;
    localparam logic [TICK_WIDTH-1:0]  TIMEOUT_MS_RST  = 8'd10;
    localparam logic [RETRY_WIDTH-1:0] MAX_RETRIES_RST = 4'd3;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ID_WIDTH-1:0] dest_id;
        logic [3:0]          frame_stage;
        logic                error_frame;
        logic [TS_WIDTH-1:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [SPAN_WIDTH-1:0] round_time;
        logic [SPAN_WIDTH-1:0] reply_time;
        logic                  last;
    } out_item_t;

    // One queue entry: the first command of an event, and whether a
    // restart-receive command follows it.
    typedef struct packed {
        logic [2:0]            action;
        logic                  restart_after;
        logic [SPAN_WIDTH-1:0] round_time;
        logic [SPAN_WIDTH-1:0] reply_time;
    } cmd_t;

endpackage

### hw/rtl/ds_twr_responder.sv
// Top level of the double-sided two-way ranging responder.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    in_data   (event)
//   out      output     out_valid / out_stall  out_data  (radio command)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One event is accepted per clock while the four-entry command queue has room.
// A command reaches the output after its event is pushed into the queue and then
// loaded into the output register; an event that causes two commands keeps its
// queue entry until the sequencer has loaded both. Reset returns the session to
// awaiting a poll, loads the register defaults and empties the queue. A stall on
// the output backs up into the queue and only then stalls the input.
module ds_twr_responder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dstwr_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dstwr_pkg::out_item_t              out_data,
    input  logic                              cfg_we,
    input  logic [dstwr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dstwr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dstwr_pkg::*;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    cmd_t q_data;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    dstwr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_data),
        .push      (push),
        .cmd       (push_cmd)
    );

    dstwr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    dstwr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/dstwr_front.sv
// Event classifier: session state, timeout and retry tracking, command generation.
module dstwr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dstwr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dstwr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              accept,
    input  dstwr_pkg::in_item_t               item,
    output logic                              push,
    output dstwr_pkg::cmd_t                   cmd
);
    import dstwr_pkg::*;

    localparam logic [1:0] ST_POLL   = 2'd0;
    localparam logic [1:0] ST_TXWAIT = 2'd1;
    localparam logic [1:0] ST_FINAL  = 2'd2;

    logic [ID_WIDTH-1:0]    anchor_id_reg;
    logic [TICK_WIDTH-1:0]  timeout_ms_reg;
    logic [RETRY_WIDTH-1:0] max_retries_reg;

    logic [1:0]             stage_reg, stage_next;
    logic [TICK_WIDTH-1:0]  elapsed_reg, elapsed_next;
    logic [RETRY_WIDTH-1:0] retry_reg, retry_next;
    logic [SPAN_WIDTH-1:0]  poll_rx_reg, poll_rx_next;
    logic [SPAN_WIDTH-1:0]  resp_tx_reg, resp_tx_next;
    logic [SPAN_WIDTH-1:0]  reply_reg, reply_next;

    logic                   new_poll;
    logic [1:0]             eff_stage;
    logic [TICK_WIDTH:0]    tick_sum;
    logic [RETRY_WIDTH:0]   retry_sum;
    logic [SPAN_WIDTH-1:0]  ts_low;
    logic                   cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_id_reg   <= ANCHOR_ID_RST;
            timeout_ms_reg  <= TIMEOUT_MS_RST;
            max_retries_reg <= MAX_RETRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANCHOR_ID:   anchor_id_reg   <= cfg_data;
                CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data;
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[RETRY_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    assign ts_low    = item.timestamp[SPAN_WIDTH-1:0];
    assign tick_sum  = {1'b0, elapsed_reg} + 1'b1;
    assign retry_sum = {1'b0, retry_reg} + 1'b1;

    // A poll addressed to us restarts the session whatever stage it is in.
    assign new_poll = (item.opcode == OP_FRAME) && (item.frame_stage == FRAME_POLL)
                      && (item.dest_id == anchor_id_reg);
    assign eff_stage = ((stage_reg == ST_TXWAIT || stage_reg == ST_FINAL) && !new_poll)
                       ? stage_reg : ST_POLL;

    always_comb
    begin
        stage_next   = eff_stage;
        elapsed_next = elapsed_reg;
        retry_next   = retry_reg;
        poll_rx_next = poll_rx_reg;
        resp_tx_next = resp_tx_reg;
        reply_next   = reply_reg;
        cmd_valid    = 1'b0;
        cmd          = '0;

        case (eff_stage)
            ST_POLL:
            begin
                if (item.opcode == OP_TICK)
                begin
                    elapsed_next = '0;
                end
                else if (item.opcode == OP_FRAME)
                begin
                    cmd_valid = 1'b1;
                    if (item.dest_id != anchor_id_reg || item.error_frame)
                    begin
                        cmd.action = ACT_RESTART;
                    end
                    else if (item.frame_stage != FRAME_POLL)
                    begin
                        cmd.action        = ACT_ERROR;
                        cmd.restart_after = 1'b1;
                    end
                    else
                    begin
                        cmd.action   = ACT_RESPONSE;
                        poll_rx_next = ts_low;
                        stage_next   = ST_TXWAIT;
                    end
                end
            end

            ST_TXWAIT:
            begin
                if (item.opcode == OP_TX_DONE)
                begin
                    resp_tx_next = ts_low;
                    reply_next   = ts_low - poll_rx_reg;
                    elapsed_next = '0;
                    stage_next   = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                if (item.opcode == OP_TICK)
                begin
                    if (tick_sum > {1'b0, timeout_ms_reg})
                    begin
                        cmd_valid         = 1'b1;
                        cmd.restart_after = 1'b1;
                        if (retry_sum > {1'b0, max_retries_reg})
                        begin
                            cmd.action = ACT_RESET;
                            retry_next = '0;
                        end
                        else
                        begin
                            // Timeout within the retry budget: only restart receive.
                            cmd.action        = ACT_RESTART;
                            cmd.restart_after = 1'b0;
                            retry_next        = retry_sum[RETRY_WIDTH-1:0];
                        end
                        elapsed_next = '0;
                        stage_next   = ST_POLL;
                    end
                    else
                    begin
                        elapsed_next = tick_sum[TICK_WIDTH-1:0];
                    end
                end
                else if (item.opcode == OP_RX_ERR)
                begin
                    retry_next = '0;
                end
                else if (item.opcode == OP_FRAME)
                begin
                    retry_next = '0;
                    cmd_valid  = 1'b1;
                    stage_next = ST_POLL;
                    if (item.error_frame)
                    begin
                        cmd.action = ACT_RESTART;
                    end
                    else if (item.frame_stage != FRAME_FINAL)
                    begin
                        cmd.action        = ACT_ERROR;
                        cmd.restart_after = 1'b1;
                    end
                    else
                    begin
                        cmd.action        = ACT_TIMING;
                        cmd.restart_after = 1'b1;
                        cmd.round_time    = ts_low - resp_tx_reg;
                        cmd.reply_time    = reply_reg;
                    end
                end
            end

            default:
            begin
                stage_next = ST_POLL;
            end
        endcase
    end

    assign push = accept && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= ST_POLL;
            elapsed_reg <= '0;
            retry_reg   <= '0;
            poll_rx_reg <= '0;
            resp_tx_reg <= '0;
            reply_reg   <= '0;
        end
        else if (accept)
        begin
            stage_reg   <= stage_next;
            elapsed_reg <= elapsed_next;
            retry_reg   <= retry_next;
            poll_rx_reg <= poll_rx_next;
            resp_tx_reg <= resp_tx_next;
            reply_reg   <= reply_next;
        end
    end

endmodule

### hw/rtl/dstwr_queue.sv
// Small command queue that decouples the classifier from the sequencer.
module dstwr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dstwr_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output dstwr_pkg::cmd_t pop_data,
    output logic            empty
);
    import dstwr_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/dstwr_back.sv
// Command sequencer: expands queue entries into radio commands in an output register.
module dstwr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  dstwr_pkg::cmd_t      q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dstwr_pkg::out_item_t out_data
);
    import dstwr_pkg::*;

    logic      valid_reg;
    out_item_t data_reg, data_next;
    logic      second_reg, second_next;
    logic      load;

    // The output register may take a new command when empty or being drained.
    assign load = !q_empty && (!valid_reg || !out_stall);

    always_comb
    begin
        data_next   = data_reg;
        second_next = second_reg;
        q_pop       = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                data_next.action     = ACT_RESTART;
                data_next.round_time = '0;
                data_next.reply_time = '0;
                data_next.last       = 1'b1;
                second_next          = 1'b0;
                q_pop                = 1'b1;
            end
            else
            begin
                data_next.action     = q_data.action;
                data_next.round_time = q_data.round_time;
                data_next.reply_time = q_data.reply_time;
                data_next.last       = !q_data.restart_after;
                second_next          = q_data.restart_after;
                q_pop                = !q_data.restart_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hw/rtl/dstwr_checker.sv
// Port-level checks on the responder's command stream, bound to the top level.
module dstwr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input dstwr_pkg::out_item_t out_data
);
    import dstwr_pkg::*;

    // A stalled command stays in place unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled command changed or dropped");

    // Only timing info carries round and reply times.
    a_times_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action != ACT_TIMING
            |-> out_data.round_time == '0 && out_data.reply_time == '0)
        else $error("times set on a command other than timing info");

    // Error, timing and reset commands are always followed by a restart.
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.action == ACT_ERROR || out_data.action == ACT_TIMING
                      || out_data.action == ACT_RESET) |-> !out_data.last)
        else $error("command that must precede a restart marked last");

    // Restart and response always close the transaction group of one event.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.action == ACT_RESTART || out_data.action == ACT_RESPONSE)
            |-> out_data.last)
        else $error("closing command not marked last");

endmodule

bind ds_twr_responder dstwr_checker u_dstwr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
